// ===== sv/rdc_pkg.sv =====
package rdc_pkg;

  // Field widths fixed by the interface.
  localparam int VALUE_W     = 32;
  localparam int RADIX_W     = 8;
  localparam int CHAR_W      = 7;

  // Default width of the converted value.
  localparam int VALUE_BITS_DEF = 32;

  // Digit store geometry.
  localparam int STORE_DEPTH = 32;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int COUNT_W     = $clog2(STORE_DEPTH + 1);
  localparam int DIGIT_W     = 6;

  // Accepted radix range.
  localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(36);

  // Character codes.
  localparam logic [DIGIT_W-1:0] DIGIT_TEN   = DIGIT_W'(10);
  localparam logic [CHAR_W-1:0]  ZERO_CHAR   = CHAR_W'(48);
  localparam logic [CHAR_W-1:0]  LETTER_BASE = CHAR_W'(65);

  // Status codes.
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  // Map a digit value to its ASCII character.
  function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] ext;
    ext = CHAR_W'(d);
    if (d < DIGIT_TEN) begin
      digit_to_char = ZERO_CHAR + ext;
    end else begin
      digit_to_char = LETTER_BASE + ext - CHAR_W'(DIGIT_TEN);
    end
  endfunction

endpackage

// ===== sv/rdc_if.sv =====
// Input channel: one value and its radix.
interface rdc_req_if;
  logic                         valid;
  logic                         ready;
  logic [rdc_pkg::VALUE_W-1:0]  value;
  logic [rdc_pkg::RADIX_W-1:0]  radix;

  modport source (output valid, output value, output radix, input ready);
  modport sink   (input valid, input value, input radix, output ready);
endinterface

// Output channel: one character of the converted number, or a result with no digit.
interface rdc_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [rdc_pkg::CHAR_W-1:0]  digit_char;
  logic                        digit_valid;
  logic                        status;
  logic                        last;

  modport source (output valid, output digit_char, output digit_valid, output status,
                  output last, input ready);
  modport sink   (input valid, input digit_char, input digit_valid, input status,
                  input last, output ready);
endinterface

// ===== sv/radix_digit_converter.sv =====
// Channel  Dir  Payload                                   Transfer
// req      in   value[31:0] signed, radix[7:0]            valid && ready
// rsp      out  digit_char[6:0], digit_valid, status, last valid && ready
//
// One conversion at a time; req.ready is high only while idle.
// Each digit takes a full pass of the bit-serial restoring divider over all
// VALUE_BITS bits of the value. The digits are then read back from the digit
// store through S_READ, S_LOAD and S_HOLD, each held in S_HOLD through any
// rsp stalls; control goes idle after the final transfer. Bad input and zero
// give a single result in the cycle after the transfer; overflow is an error.
// Synchronous reset returns the control to idle; the store is not cleared.
module radix_digit_converter #(
  parameter int VALUE_BITS = rdc_pkg::VALUE_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  rdc_req_if.sink    req,
  rdc_rsp_if.source  rsp
);

  import rdc_pkg::*;

  localparam int BITCNT_W = $clog2(VALUE_BITS);
  localparam logic [BITCNT_W-1:0] BIT_LAST = BITCNT_W'(VALUE_BITS - 1);
  localparam logic [COUNT_W-1:0]  COUNT_FULL = COUNT_W'(STORE_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_READ,
    S_LOAD,
    S_HOLD
  } state_t;

  state_t                state;
  logic [VALUE_BITS-1:0] work;
  logic [DIGIT_W-1:0]    rem;
  logic [DIGIT_W-1:0]    radix;
  logic [BITCNT_W-1:0]   bit_cnt;
  logic                  nz;
  logic [COUNT_W-1:0]    count;

  logic                  out_vld;
  logic [CHAR_W-1:0]     out_char;
  logic                  out_dvalid;
  logic                  out_status;
  logic                  out_last;

  logic [VALUE_BITS-1:0] v_in;
  logic                  in_bad;
  logic [DIGIT_W:0]      rem_sh;
  logic [DIGIT_W:0]      diff;
  logic                  ge;
  logic [DIGIT_W-1:0]    rem_next;
  logic [VALUE_BITS-1:0] work_next;
  logic                  wr_en;
  logic [ADDR_W-1:0]     rd_addr;
  logic [DIGIT_W-1:0]    rd_data;

  // Input value at the configured width, sign-extended or truncated.
  assign v_in   = VALUE_BITS'($signed(req.value));
  assign in_bad = v_in[VALUE_BITS-1] || (req.radix < RADIX_MIN) || (req.radix > RADIX_MAX);

  // One step of restoring division: shift in the next dividend bit.
  assign rem_sh    = {rem, work[VALUE_BITS-1]};
  assign diff      = rem_sh - {1'b0, radix};
  assign ge        = (rem_sh >= {1'b0, radix});
  assign rem_next  = ge ? diff[DIGIT_W-1:0] : rem_sh[DIGIT_W-1:0];
  assign work_next = {work[VALUE_BITS-2:0], ge};

  // Store the remainder when a division ends with room left in the store.
  assign wr_en   = (state == S_DIV) && (bit_cnt == '0) && (count != COUNT_FULL);
  assign rd_addr = count[ADDR_W-1:0] - ADDR_W'(1);

  rdc_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count[ADDR_W-1:0]),
    .wr_data (rem_next),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Handshake and payload.
  assign req.ready       = (state == S_IDLE);
  assign rsp.valid       = out_vld;
  assign rsp.digit_char  = out_char;
  assign rsp.digit_valid = out_dvalid;
  assign rsp.status      = out_status;
  assign rsp.last        = out_last;

  // Control sequencer with the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      out_vld <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            if (in_bad || (v_in == '0)) begin
              out_vld    <= 1'b1;
              out_char   <= '0;
              out_dvalid <= 1'b0;
              out_status <= in_bad ? STATUS_ERR : STATUS_OK;
              out_last   <= 1'b1;
              state      <= S_HOLD;
            end else begin
              work    <= v_in;
              radix   <= req.radix[DIGIT_W-1:0];
              rem     <= '0;
              nz      <= 1'b0;
              bit_cnt <= BIT_LAST;
              count   <= '0;
              state   <= S_DIV;
            end
          end
        end
        S_DIV: begin
          work <= work_next;
          if (bit_cnt != '0) begin
            rem     <= rem_next;
            nz      <= nz | ge;
            bit_cnt <= bit_cnt - BITCNT_W'(1);
          end else if (count == COUNT_FULL) begin
            // More digits than the store holds.
            out_vld    <= 1'b1;
            out_char   <= '0;
            out_dvalid <= 1'b0;
            out_status <= STATUS_ERR;
            out_last   <= 1'b1;
            state      <= S_HOLD;
          end else begin
            // Digit stored; start the next division or read back when done.
            count   <= count + COUNT_W'(1);
            rem     <= '0;
            nz      <= 1'b0;
            bit_cnt <= BIT_LAST;
            if (!(nz | ge)) begin
              state <= S_READ;
            end
          end
        end
        S_READ: begin
          // Read address is issued this cycle; data arrives next cycle.
          state <= S_LOAD;
        end
        S_LOAD: begin
          out_vld    <= 1'b1;
          out_char   <= digit_to_char(rd_data);
          out_dvalid <= 1'b1;
          out_status <= STATUS_OK;
          out_last   <= (count == COUNT_W'(1));
          count      <= count - COUNT_W'(1);
          state      <= S_HOLD;
        end
        S_HOLD: begin
          if (rsp.ready) begin
            out_vld <= 1'b0;
            state   <= out_last ? S_IDLE : S_READ;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== sv/rdc_ram.sv =====
module rdc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
